@@ src/lsf_pkg.sv @@
// ----------------------------------------------------------------------------
// lsf_pkg
// shared types and constants of the line substring filter
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int LINE_MAX_DEF = 63;
  localparam int PAT_MAX_DEF  = 16;

  localparam int BYTE_W     = 8;
  localparam int PAT_LEN_W  = 5;
  localparam int JOB_LEN_W  = 6;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_SAT    = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_SEND,
    BK_STATUS
  } bk_state_t;

  // one finished matching line or end of stream, handed from front to back
  typedef struct packed {
    logic                 bank;
    logic [JOB_LEN_W-1:0] len;
    logic                 trunc;
    logic                 emit_line;
    logic                 is_eof;
    logic [COUNT_W-1:0]   count;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

@@ src/lsf_in_if.sv @@
// ----------------------------------------------------------------------------
// lsf_in_if
// text input channel, one byte or end-of-file marker per beat
// ----------------------------------------------------------------------------
interface lsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       eof_flag;

  modport source (output valid, output data_byte, output eof_flag, input ready);
  modport sink   (input valid, input data_byte, input eof_flag, output ready);
endinterface

@@ src/lsf_out_if.sv @@
// ----------------------------------------------------------------------------
// lsf_out_if
// result channel, one line byte or status per beat
// ----------------------------------------------------------------------------
interface lsf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        line_empty;
  logic        line_end;
  logic        line_truncated;
  logic        is_status;
  logic        no_match_in_file;
  logic [15:0] matching_lines;

  modport source (output valid, output out_byte, output line_empty, output line_end,
                  output line_truncated, output is_status, output no_match_in_file,
                  output matching_lines, input ready);
  modport sink   (input valid, input out_byte, input line_empty, input line_end,
                  input line_truncated, input is_status, input no_match_in_file,
                  input matching_lines, output ready);
endinterface

@@ src/lsf_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lsf_cfg_if
// configuration write channel, register index and data per beat
// ----------------------------------------------------------------------------
interface lsf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/lsf_line_ram.sv @@
// ----------------------------------------------------------------------------
// lsf_line_ram
// two-bank line store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lsf_line_ram
  import lsf_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              wr_bank,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic              rd_bank,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [2][LINE_MAX];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_bank][rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/lsf_fifo.sv @@
// ----------------------------------------------------------------------------
// lsf_fifo
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module lsf_fifo
  import lsf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic not_empty
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = cnt_r[1];
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

endmodule

@@ src/lsf_front.sv @@
// ----------------------------------------------------------------------------
// lsf_front
// intake: pattern registers, line store writes, window match, line jobs
// ----------------------------------------------------------------------------
module lsf_front
  import lsf_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  parameter int PAT_MAX  = PAT_MAX_DEF,
  localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  lsf_in_if.sink            in_chan,
  lsf_cfg_if.sink           cfg_chan,
  output logic              job_push,
  output job_t              job_data,
  input  logic              job_full,
  input  bank_rel_t         bank_rel,
  output logic              ram_we,
  output logic              ram_bank,
  output logic [IDX_W-1:0]  ram_idx,
  output logic [BYTE_W-1:0] ram_data
);

  localparam int LEN_W = $clog2(LINE_MAX + 1);
  localparam int WIN_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [PAT_LEN_W-1:0]  pat_len_r;
  logic                  wr_bank_r;
  logic [1:0]            busy_r, busy_nxt;
  logic [LEN_W-1:0]      len_r;
  logic                  ovf_r;
  logic [BYTE_W-1:0]     win_r [PAT_MAX];
  logic [BYTE_W-1:0]     win_sh [PAT_MAX];
  logic [PAT_LEN_W-1:0]  fill_r, fill_nxt;
  logic                  matched_r;
  logic [COUNT_W-1:0]    count_r, cnt_inc, count_line;

  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [PAT_LEN_W-1:0]    act_len;
  logic                    all_ok, hit_now;
  logic                    accept, is_eof, is_nl, finish, line_hit, uses_bank, room;

  assign pat_all = {pat_hi_r, pat_lo_r};
  assign act_len = (pat_len_r > PAT_LEN_W'(PAT_MAX)) ? PAT_LEN_W'(PAT_MAX) : pat_len_r;

  assign in_chan.ready = !job_full && !busy_r[wr_bank_r];
  assign cfg_chan.ready = 1'b1;

  assign accept = in_chan.valid && in_chan.ready;
  assign is_eof = in_chan.eof_flag;
  assign is_nl  = !is_eof && (in_chan.data_byte == NEWLINE_BYTE);
  assign finish = accept && (is_eof || is_nl);
  assign room   = (len_r < LEN_W'(LINE_MAX));

  // window after shifting in the new byte
  always_comb begin
    for (int i = 0; i < PAT_MAX - 1; i++) begin
      win_sh[i] = win_r[i+1];
    end
    win_sh[PAT_MAX-1] = in_chan.data_byte;
  end

  assign fill_nxt = (fill_r < PAT_LEN_W'(PAT_MAX)) ? fill_r + PAT_LEN_W'(1) : fill_r;

  always_comb begin
    logic [PAT_LEN_W-1:0] wi;
    all_ok = 1'b1;
    wi     = '0;
    for (int k = 0; k < PAT_MAX; k++) begin
      wi = PAT_LEN_W'(PAT_MAX) - act_len + PAT_LEN_W'(k);
      if ((PAT_LEN_W'(k) < act_len) &&
          (win_sh[wi[WIN_W-1:0]] != pat_all[k*BYTE_W +: BYTE_W])) begin
        all_ok = 1'b0;
      end
    end
  end

  assign hit_now = (act_len != '0) && (fill_nxt >= act_len) && all_ok;

  assign line_hit   = matched_r || (act_len == '0);
  assign cnt_inc    = (count_r < COUNT_SAT) ? count_r + COUNT_W'(1) : count_r;
  assign count_line = line_hit ? cnt_inc : count_r;

  assign job_push           = finish && (line_hit || is_eof);
  assign job_data.bank      = wr_bank_r;
  assign job_data.len       = JOB_LEN_W'(len_r);
  assign job_data.trunc     = ovf_r;
  assign job_data.emit_line = line_hit;
  assign job_data.is_eof    = is_eof;
  assign job_data.count     = count_line;

  assign uses_bank = finish && line_hit && (len_r != '0);

  assign ram_we   = accept && !is_eof && !is_nl && room;
  assign ram_bank = wr_bank_r;
  assign ram_idx  = len_r[IDX_W-1:0];
  assign ram_data = in_chan.data_byte;

  always_comb begin
    busy_nxt = busy_r;
    if (bank_rel.valid) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end
    if (uses_bank) begin
      busy_nxt[wr_bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_PATTERN_LOW:    pat_lo_r  <= cfg_chan.data;
        REG_PATTERN_HIGH:   pat_hi_r  <= cfg_chan.data;
        REG_PATTERN_LENGTH: pat_len_r <= cfg_chan.data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_bank_r <= 1'b0;
      busy_r    <= '0;
      len_r     <= '0;
      ovf_r     <= 1'b0;
      fill_r    <= '0;
      matched_r <= 1'b0;
      count_r   <= '0;
      for (int i = 0; i < PAT_MAX; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      busy_r <= busy_nxt;
      if (finish) begin
        len_r     <= '0;
        ovf_r     <= 1'b0;
        fill_r    <= '0;
        matched_r <= 1'b0;
        count_r   <= is_eof ? '0 : count_line;
        if (uses_bank) begin
          wr_bank_r <= ~wr_bank_r;
        end
      end else if (accept) begin
        if (room) begin
          len_r <= len_r + LEN_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
        win_r     <= win_sh;
        fill_r    <= fill_nxt;
        matched_r <= matched_r || hit_now;
      end
    end
  end

endmodule

@@ src/lsf_back.sv @@
// ----------------------------------------------------------------------------
// lsf_back
// emitter: reads queued line jobs and drives the result channel
// ----------------------------------------------------------------------------
module lsf_back
  import lsf_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  job_t              job_in,
  output logic              job_pop,
  output bank_rel_t         bank_rel,
  output logic              ram_re,
  output logic              ram_bank,
  output logic [IDX_W-1:0]  ram_idx,
  input  logic [BYTE_W-1:0] ram_data,
  lsf_out_if.source         out_chan
);

  bk_state_t            state_r, state_nxt;
  job_t                 job_r;
  logic [JOB_LEN_W-1:0] idx_r, idx_nxt;
  logic                 empty_line, last;

  assign empty_line = (job_r.len == '0);
  assign last       = empty_line || ((idx_r + JOB_LEN_W'(1)) == job_r.len);

  assign ram_re   = (state_r == BK_FETCH);
  assign ram_bank = job_r.bank;
  assign ram_idx  = idx_r[IDX_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    job_pop       = 1'b0;
    bank_rel      = '0;
    out_chan.valid            = 1'b0;
    out_chan.out_byte         = '0;
    out_chan.line_empty       = 1'b0;
    out_chan.line_end         = 1'b0;
    out_chan.line_truncated   = 1'b0;
    out_chan.is_status        = 1'b0;
    out_chan.no_match_in_file = 1'b0;
    out_chan.matching_lines   = job_r.count;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          idx_nxt = '0;
          if (!job_in.emit_line) begin
            state_nxt = BK_STATUS;
          end else if (job_in.len == '0) begin
            state_nxt = BK_SEND;
          end else begin
            state_nxt = BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        state_nxt = BK_SEND;
      end
      BK_SEND: begin
        out_chan.valid          = 1'b1;
        out_chan.out_byte       = empty_line ? '0 : ram_data;
        out_chan.line_empty     = empty_line;
        out_chan.line_end       = last;
        out_chan.line_truncated = job_r.trunc;
        if (out_chan.ready) begin
          if (!last) begin
            idx_nxt   = idx_r + JOB_LEN_W'(1);
            state_nxt = BK_FETCH;
          end else begin
            bank_rel.valid = !empty_line;
            bank_rel.bank  = job_r.bank;
            state_nxt      = job_r.is_eof ? BK_STATUS : BK_IDLE;
          end
        end
      end
      BK_STATUS: begin
        out_chan.valid            = 1'b1;
        out_chan.is_status        = 1'b1;
        out_chan.no_match_in_file = (job_r.count == '0);
        if (out_chan.ready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job_in;
    end
  end

endmodule

@@ src/line_substring_filter.sv @@
// ----------------------------------------------------------------------------
// line_substring_filter
// fixed-string line filter: passes on the lines that hold the pattern
// ----------------------------------------------------------------------------
// in_chan takes one text byte or an end-of-file marker per beat; byte 10 ends
// a line. cfg_chan writes pattern_low, pattern_high and pattern_length; the
// user must do so only while the block is idle, which the block itself does
// not enforce. cfg_chan is always ready. out_chan gives each matching line one
// byte per beat (an empty line as one beat with line_empty set), the last beat
// with line_end, and after end of file one status beat with the count of
// matching lines. Intake runs at one byte per cycle; a matching line goes to a
// two-entry job queue and one of two line-store banks, and intake stalls while
// the queue is full or the bank it would write is still being sent.
// Each line byte is first read from the store, then sent; empty line and
// status beats need no store read. A stalled receiver holds the current
// beat; intake runs on until the queue or the line store bank blocks it.
// Reset clears the pattern, the counters and the queue; no clearing pass.
// ----------------------------------------------------------------------------
module line_substring_filter
  import lsf_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  parameter int PAT_MAX  = PAT_MAX_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lsf_in_if.sink    in_chan,
  lsf_cfg_if.sink   cfg_chan,
  lsf_out_if.source out_chan
);

  localparam int IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  logic              push, full, pop, not_empty;
  job_t              push_data, pop_data;
  bank_rel_t         bank_rel;
  logic              ram_we, ram_wbank, ram_re, ram_rbank;
  logic [IDX_W-1:0]  ram_widx, ram_ridx;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  lsf_front #(.LINE_MAX(LINE_MAX), .PAT_MAX(PAT_MAX)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .job_push (push),
    .job_data (push_data),
    .job_full (full),
    .bank_rel (bank_rel),
    .ram_we   (ram_we),
    .ram_bank (ram_wbank),
    .ram_idx  (ram_widx),
    .ram_data (ram_wdata)
  );

  lsf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  lsf_line_ram #(.LINE_MAX(LINE_MAX)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_bank (ram_wbank),
    .wr_idx  (ram_widx),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_bank (ram_rbank),
    .rd_idx  (ram_ridx),
    .rd_data (ram_rdata)
  );

  lsf_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (not_empty),
    .job_in    (pop_data),
    .job_pop   (pop),
    .bank_rel  (bank_rel),
    .ram_re    (ram_re),
    .ram_bank  (ram_rbank),
    .ram_idx   (ram_ridx),
    .ram_data  (ram_rdata),
    .out_chan  (out_chan)
  );

endmodule
